// File: src/scp_pkg.sv
// shared types and constants for the substitute command splitter
`default_nettype none

package scp_pkg;

    // parse phase of the command body
    typedef enum logic [1:0] {
        PH_DELIM,
        PH_PAT,
        PH_REP,
        PH_FLAGS
    } scp_phase_t;

    // byte roles
    localparam logic [2:0] ROLE_DELIM = 3'd0;
    localparam logic [2:0] ROLE_PAT   = 3'd1;
    localparam logic [2:0] ROLE_REP   = 3'd2;
    localparam logic [2:0] ROLE_FLAG  = 3'd3;
    localparam logic [2:0] ROLE_IGN   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_BAD_DELIM = 3'd2;
    localparam logic [2:0] ST_BAD_FLAG  = 3'd3;
    localparam logic [2:0] ST_CONFLICT  = 3'd4;

    // flag bit positions
    localparam int FB_G    = 0;
    localparam int FB_C    = 1;
    localparam int FB_N    = 2;
    localparam int FB_I    = 3;
    localparam int FB_BIGI = 4;
    localparam int FB_P    = 5;
    localparam int FB_E    = 6;

    // characters of interest
    localparam logic [7:0] CH_G      = 8'h67;  // g
    localparam logic [7:0] CH_C      = 8'h63;  // c
    localparam logic [7:0] CH_N      = 8'h6E;  // n
    localparam logic [7:0] CH_I      = 8'h69;  // i
    localparam logic [7:0] CH_BIGI   = 8'h49;  // I
    localparam logic [7:0] CH_P      = 8'h70;  // p
    localparam logic [7:0] CH_E      = 8'h65;  // e
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam int LEN_W  = 12;
    localparam int FLAG_W = 7;

    // parser state carried between requests
    typedef struct packed {
        scp_phase_t         phase;
        logic [7:0]         delimiter;
        logic               esc;
        logic [FLAG_W-1:0]  flags;
        logic [2:0]         err;
        logic [LEN_W-1:0]   pat_cnt;
        logic [LEN_W-1:0]   rep_cnt;
    } scp_state_t;

    localparam scp_state_t STATE_RST = '{
        phase:     PH_DELIM,
        delimiter: 8'd0,
        esc:       1'b0,
        flags:     '0,
        err:       ST_OK,
        pat_cnt:   '0,
        rep_cnt:   '0
    };

    // one result
    typedef struct packed {
        logic [2:0]         role;
        logic               done_res;
        logic [2:0]         status;
        logic [FLAG_W-1:0]  flag_set;
        logic [LEN_W-1:0]   pattern_len;
        logic [LEN_W-1:0]   replacement_len;
    } scp_result_t;

endpackage

`default_nettype wire

// File: src/scp_cmd_if.sv
// request channel carrying command body bytes
`default_nettype none

interface scp_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       empty_req;

    modport source (output valid, output ch, output last, output empty_req, input ready);
    modport sink   (input valid, input ch, input last, input empty_req, output ready);
endinterface

`default_nettype wire

// File: src/scp_res_if.sv
// result channel carrying byte role and command summary
`default_nettype none

interface scp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  role;
    logic        done_res;
    logic [2:0]  status;
    logic [6:0]  flag_set;
    logic [11:0] pattern_len;
    logic [11:0] replacement_len;

    modport source (output valid, output role, output done_res, output status,
                    output flag_set, output pattern_len, output replacement_len,
                    input ready);
    modport sink   (input valid, input role, input done_res, input status,
                    input flag_set, input pattern_len, input replacement_len,
                    output ready);
endinterface

`default_nettype wire

// File: src/scp_step.sv
// per-byte parse step: next state and result from current state and one byte
`default_nettype none

module scp_step #(
    parameter int BODY_MAX = 4096
) (
    input  scp_pkg::scp_state_t  cur,
    input  logic [7:0]           ch,
    input  logic                 last,
    input  logic                 empty_req,
    output scp_pkg::scp_state_t  nxt,
    output scp_pkg::scp_result_t res
);

    localparam logic [scp_pkg::LEN_W-1:0] LEN_CAP =
        scp_pkg::LEN_W'((BODY_MAX - 1 < 4095) ? BODY_MAX - 1 : 4095);

    logic                       good_delim;
    logic                       hit_delim;
    logic                       flag_known;
    logic [scp_pkg::FLAG_W-1:0] flag_bit;
    logic [2:0]                 final_st;

    // delimiter must be printable punctuation
    always_comb
    begin
        good_delim = (ch > scp_pkg::CH_SPACE) && (ch < scp_pkg::CH_DEL);
        if (ch == scp_pkg::CH_BSLASH)
            good_delim = 1'b0;
        if (ch >= 8'h30 && ch <= 8'h39)
            good_delim = 1'b0;
        if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
            good_delim = 1'b0;
    end

    // flag byte decode
    always_comb
    begin
        flag_known = 1'b1;
        flag_bit   = '0;
        case (ch) inside
            scp_pkg::CH_G:    flag_bit[scp_pkg::FB_G]    = 1'b1;
            scp_pkg::CH_C:    flag_bit[scp_pkg::FB_C]    = 1'b1;
            scp_pkg::CH_N:    flag_bit[scp_pkg::FB_N]    = 1'b1;
            scp_pkg::CH_I:    flag_bit[scp_pkg::FB_I]    = 1'b1;
            scp_pkg::CH_BIGI: flag_bit[scp_pkg::FB_BIGI] = 1'b1;
            scp_pkg::CH_P:    flag_bit[scp_pkg::FB_P]    = 1'b1;
            scp_pkg::CH_E:    flag_bit[scp_pkg::FB_E]    = 1'b1;
            scp_pkg::CH_SPACE, scp_pkg::CH_TAB: flag_bit = '0;
            default:          flag_known = 1'b0;
        endcase
    end

    assign hit_delim = !cur.esc && (ch == cur.delimiter);

    always_comb
    begin
        nxt      = cur;
        res      = '0;
        res.role = scp_pkg::ROLE_IGN;
        final_st = scp_pkg::ST_OK;
        if (empty_req)
        begin
            nxt          = scp_pkg::STATE_RST;
            res.done_res = 1'b1;
            res.status   = scp_pkg::ST_EMPTY;
        end
        else
        begin
            if (cur.err != scp_pkg::ST_OK)
            begin
                res.role = scp_pkg::ROLE_IGN;
            end
            else
            begin
                unique case (cur.phase) inside
                    scp_pkg::PH_DELIM:
                    begin
                        res.role = scp_pkg::ROLE_DELIM;
                        if (good_delim)
                        begin
                            nxt.delimiter = ch;
                            nxt.phase     = scp_pkg::PH_PAT;
                        end
                        else
                        begin
                            nxt.err = scp_pkg::ST_BAD_DELIM;
                        end
                    end
                    scp_pkg::PH_PAT, scp_pkg::PH_REP:
                    begin
                        if (hit_delim)
                        begin
                            res.role  = scp_pkg::ROLE_DELIM;
                            nxt.phase = (cur.phase == scp_pkg::PH_PAT) ?
                                        scp_pkg::PH_REP : scp_pkg::PH_FLAGS;
                        end
                        else
                        begin
                            if (cur.esc)
                                nxt.esc = 1'b0;
                            else if (ch == scp_pkg::CH_BSLASH && !last)
                                nxt.esc = 1'b1;
                            if (cur.phase == scp_pkg::PH_PAT)
                            begin
                                res.role = scp_pkg::ROLE_PAT;
                                if (cur.pat_cnt < LEN_CAP)
                                    nxt.pat_cnt = cur.pat_cnt + 1'b1;
                            end
                            else
                            begin
                                res.role = scp_pkg::ROLE_REP;
                                if (cur.rep_cnt < LEN_CAP)
                                    nxt.rep_cnt = cur.rep_cnt + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res.role = scp_pkg::ROLE_FLAG;
                        if (flag_known)
                            nxt.flags = cur.flags | flag_bit;
                        else
                            nxt.err = scp_pkg::ST_BAD_FLAG;
                    end
                endcase
            end

            // summary on the final byte, then back to reset state
            if (last)
            begin
                final_st = nxt.err;
                if (final_st == scp_pkg::ST_OK && nxt.flags[scp_pkg::FB_I] &&
                    nxt.flags[scp_pkg::FB_BIGI])
                    final_st = scp_pkg::ST_CONFLICT;
                res.done_res        = 1'b1;
                res.status          = final_st;
                res.flag_set        = nxt.flags;
                res.pattern_len     = nxt.pat_cnt;
                res.replacement_len = nxt.rep_cnt;
                nxt                 = scp_pkg::STATE_RST;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/substitute_command_splitter.sv
// top level of the substitute command splitter
//
// usage: the cmd channel carries the body of a substitute command one byte
// per request (ch, last marks the final byte, empty_req stands for a whole
// empty body). the res channel returns exactly one result per request: the
// role of that byte, and on the final byte (done_res) the status, flag set
// and the saturating pattern and replacement lengths.
//
// timing: a request lands in an input register, one combinational parse
// step against the parser state produces the result into the output
// register. a result becomes valid once its request has passed the input
// register and then the output register, and while results are taken one
// request is taken every cycle; the parser state update is the single
// per-byte loop.
//
// reset: rst_n clears both register valids and returns the parser to the
// expect-delimiter phase with all counts, flags and status cleared.
//
// stall: when res.ready is low the output register holds its result, the
// input register fills, and cmd.ready drops until the result is taken.
`default_nettype none

module substitute_command_splitter #(
    parameter int BODY_MAX = 4096
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scp_cmd_if.sink    cmd,
    scp_res_if.source  res
);

    localparam logic [scp_pkg::LEN_W-1:0] LEN_CAP =
        scp_pkg::LEN_W'((BODY_MAX - 1 < 4095) ? BODY_MAX - 1 : 4095);

    // input register
    logic       in_vld_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       empty_reg;

    // parser state
    scp_pkg::scp_state_t  state_reg;
    scp_pkg::scp_state_t  state_next;

    // output register
    logic                 out_vld_reg;
    scp_pkg::scp_result_t res_reg;
    scp_pkg::scp_result_t res_next;

    logic adv;

    // move a request forward when the output register is free or draining
    assign adv       = in_vld_reg && (!out_vld_reg || res.ready);
    assign cmd.ready = !in_vld_reg || adv;

    scp_step #(
        .BODY_MAX (BODY_MAX)
    ) u_step (
        .cur       (state_reg),
        .ch        (ch_reg),
        .last      (last_reg),
        .empty_req (empty_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (cmd.ready)
            in_vld_reg <= cmd.valid;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            ch_reg    <= cmd.ch;
            last_reg  <= cmd.last;
            empty_reg <= cmd.empty_req;
        end
    end

    // parser state advances with each request that moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= scp_pkg::STATE_RST;
        else if (adv)
            state_reg <= state_next;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= 1'b1;
        else if (res.ready)
            out_vld_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res.valid           = out_vld_reg;
    assign res.role            = res_reg.role;
    assign res.done_res        = res_reg.done_res;
    assign res.status          = res_reg.status;
    assign res.flag_set        = res_reg.flag_set;
    assign res.pattern_len     = res_reg.pattern_len;
    assign res.replacement_len = res_reg.replacement_len;

    // summary fields are zero except on the final result
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res_reg.done_res) |->
        (res_reg.status == scp_pkg::ST_OK && res_reg.flag_set == '0 &&
         res_reg.pattern_len == '0 && res_reg.replacement_len == '0))
        else $error("summary fields set on a non-final result");

    // a finished body leaves the parser in its reset state
    a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.done_res) |=> (state_reg == scp_pkg::STATE_RST))
        else $error("parser state not cleared after final byte");

    // ignored role only after a latched error or for an empty body
    a_ign_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.role == scp_pkg::ROLE_IGN) |->
        (state_reg.err != scp_pkg::ST_OK || empty_reg))
        else $error("byte ignored without an error");

    // lengths never pass the cap
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pat_cnt <= LEN_CAP && state_reg.rep_cnt <= LEN_CAP))
        else $error("field length beyond cap");

    // a latched error holds until the body ends
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.err != scp_pkg::ST_OK && !(adv && res_next.done_res)) |=>
        (state_reg.err == $past(state_reg.err)))
        else $error("latched error changed mid-body");

endmodule

`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for the substitute command splitter
`timescale 1ns / 100ps

module testbench;

    localparam int BODY_MAX = 4096;
    // lengths stop at the smaller of the field maximum and BODY_MAX-1
    localparam logic [scp_pkg::LEN_W-1:0] LEN_CAP =
        (BODY_MAX - 1 < 4095) ? scp_pkg::LEN_W'(BODY_MAX - 1) : scp_pkg::LEN_W'(4095);
    // cycles with no request and no result moving before the run is called dead
    localparam int QUIET_LIMIT = 2000;
    // random requests per idling phase
    localparam int PHASE_REQUESTS = 650;
    // keep the log readable when the block is badly broken
    localparam int REPORT_CAP = 100;

    // flag bytes the parser accepts, separators included
    localparam logic [7:0] FLAG_CHARS [9] = '{scp_pkg::CH_G, scp_pkg::CH_C, scp_pkg::CH_N,
                                              scp_pkg::CH_I, scp_pkg::CH_BIGI,
                                              scp_pkg::CH_P, scp_pkg::CH_E,
                                              scp_pkg::CH_SPACE, scp_pkg::CH_TAB};

    typedef logic [7:0] byte_q_t [$];

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    scp_cmd_if cmd ();
    scp_res_if res ();

    substitute_command_splitter #(
        .BODY_MAX (BODY_MAX)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // printable punctuation only: no letters, digits or backslash
    function automatic bit is_good_delim(logic [7:0] c);
        if (c == scp_pkg::CH_BSLASH)
            return 1'b0;
        if (c >= "0" && c <= "9")
            return 1'b0;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return 1'b0;
        return (c > scp_pkg::CH_SPACE) && (c < scp_pkg::CH_DEL);
    endfunction

    // parser prediction and result checking
    class scp_scoreboard;
        scp_pkg::scp_state_t  st;
        scp_pkg::scp_result_t expected_q [$];
        int                   errors;
        int                   requests;
        int                   bodies [5];
        int                   saturated;

        function new();
            st = scp_pkg::STATE_RST;
        endfunction

        // advance the predicted parser by one accepted request
        function void note_request(logic [7:0] c, logic l, logic e);
            scp_pkg::scp_result_t       want;
            logic [scp_pkg::FLAG_W-1:0] fbit;
            bit                         known;
            want = '0;
            requests++;
            // an empty request is a whole body on its own and drops any partial one
            if (e) begin
                st = scp_pkg::STATE_RST;
                want.role     = scp_pkg::ROLE_IGN;
                want.done_res = 1'b1;
                want.status   = scp_pkg::ST_EMPTY;
                bodies[scp_pkg::ST_EMPTY]++;
                expected_q.push_back(want);
                return;
            end
            if (st.err != scp_pkg::ST_OK) begin
                want.role = scp_pkg::ROLE_IGN;
            end else begin
                case (st.phase)
                    scp_pkg::PH_DELIM: begin
                        want.role = scp_pkg::ROLE_DELIM;
                        if (is_good_delim(c)) begin
                            st.delimiter = c;
                            st.phase     = scp_pkg::PH_PAT;
                        end else begin
                            st.err = scp_pkg::ST_BAD_DELIM;
                        end
                    end
                    scp_pkg::PH_PAT, scp_pkg::PH_REP: begin
                        if (!st.esc && c == st.delimiter) begin
                            want.role = scp_pkg::ROLE_DELIM;
                            st.phase  = (st.phase == scp_pkg::PH_PAT) ?
                                        scp_pkg::PH_REP : scp_pkg::PH_FLAGS;
                        end else begin
                            want.role = (st.phase == scp_pkg::PH_PAT) ?
                                        scp_pkg::ROLE_PAT : scp_pkg::ROLE_REP;
                            // escape pair stays in the field; a final backslash is literal
                            if (st.esc)
                                st.esc = 1'b0;
                            else if (c == scp_pkg::CH_BSLASH && !l)
                                st.esc = 1'b1;
                            if (st.phase == scp_pkg::PH_PAT) begin
                                if (st.pat_cnt < LEN_CAP)
                                    st.pat_cnt++;
                            end else begin
                                if (st.rep_cnt < LEN_CAP)
                                    st.rep_cnt++;
                            end
                        end
                    end
                    default: begin
                        want.role = scp_pkg::ROLE_FLAG;
                        fbit  = '0;
                        known = 1'b1;
                        case (c)
                            scp_pkg::CH_G:    fbit[scp_pkg::FB_G]    = 1'b1;
                            scp_pkg::CH_C:    fbit[scp_pkg::FB_C]    = 1'b1;
                            scp_pkg::CH_N:    fbit[scp_pkg::FB_N]    = 1'b1;
                            scp_pkg::CH_I:    fbit[scp_pkg::FB_I]    = 1'b1;
                            scp_pkg::CH_BIGI: fbit[scp_pkg::FB_BIGI] = 1'b1;
                            scp_pkg::CH_P:    fbit[scp_pkg::FB_P]    = 1'b1;
                            scp_pkg::CH_E:    fbit[scp_pkg::FB_E]    = 1'b1;
                            scp_pkg::CH_SPACE, scp_pkg::CH_TAB: fbit = '0;
                            default:          known                  = 1'b0;
                        endcase
                        if (known)
                            st.flags = st.flags | fbit;
                        else
                            st.err = scp_pkg::ST_BAD_FLAG;
                    end
                endcase
            end
            if (l) begin
                want.done_res = 1'b1;
                want.status   = st.err;
                if (st.err == scp_pkg::ST_OK && st.flags[scp_pkg::FB_I] &&
                    st.flags[scp_pkg::FB_BIGI])
                    want.status = scp_pkg::ST_CONFLICT;
                want.flag_set        = st.flags;
                want.pattern_len     = st.pat_cnt;
                want.replacement_len = st.rep_cnt;
                bodies[want.status]++;
                if (st.pat_cnt == LEN_CAP || st.rep_cnt == LEN_CAP)
                    saturated++;
                st = scp_pkg::STATE_RST;
            end
            expected_q.push_back(want);
        endfunction

        function void compare(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, seen);
            end
        endfunction

        // match one result against the oldest prediction
        function void check_result(scp_pkg::scp_result_t got);
            scp_pkg::scp_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare("role", want.role, got.role);
            compare("done_res", want.done_res, got.done_res);
            compare("status", want.status, got.status);
            compare("flag_set", want.flag_set, got.flag_set);
            compare("pattern_len", want.pattern_len, got.pattern_len);
            compare("replacement_len", want.replacement_len, got.replacement_len);
        endfunction
    endclass

    scp_scoreboard sb;

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one request; random idle cycles ahead of it, returns once it is accepted
    task automatic send_request(logic [7:0] c, logic l, logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.ch        <= c;
        cmd.last      <= l;
        cmd.empty_req <= e;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    // send a body with last on the final byte; abort swaps the final byte for an
    // empty request so the body in progress gets discarded
    task automatic send_body(byte_q_t q, bit abort);
        for (int i = 0; i < q.size(); i++) begin
            if (abort && i == q.size() - 1)
                send_request(8'($urandom), 1'($urandom), 1'b1);
            else
                send_request(q[i], i == q.size() - 1, 1'b0);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], i == s.len() - 1, 1'b0);
    endtask

    // stop sending and hold off until every predicted result has come back
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_q.size() != 0);
        @(posedge clk);
    endtask

    // pattern or replacement content; delimiters and backslashes always escaped,
    // other bytes escaped now and then
    function automatic byte_q_t make_field(logic [7:0] d);
        byte_q_t    q;
        logic [7:0] b;
        int         n;
        n = $urandom_range(0, 10);
        repeat (n) begin
            b = 8'($urandom);
            if (b == d || b == scp_pkg::CH_BSLASH || $urandom_range(7) == 0)
                q.push_back(scp_pkg::CH_BSLASH);
            q.push_back(b);
        end
        return q;
    endfunction

    // mostly well formed bodies, some truncated, some raw noise
    function automatic byte_q_t make_body();
        byte_q_t    q;
        logic [7:0] d;
        int         kind;
        int         n;
        kind = $urandom_range(99);
        // noise: first byte is usually a bad delimiter
        if (kind < 10) begin
            n = $urandom_range(1, 6);
            repeat (n) q.push_back(8'($urandom));
            return q;
        end
        do
            d = 8'($urandom_range(8'h21, 8'h7E));
        while (!is_good_delim(d));
        q.push_back(d);
        q = {q, make_field(d)};
        // body ends inside the pattern, sometimes on a lone backslash
        if (kind < 20) begin
            if (kind < 15)
                q.push_back(scp_pkg::CH_BSLASH);
            return q;
        end
        q.push_back(d);
        q = {q, make_field(d)};
        q.push_back(d);
        n = $urandom_range(0, 4);
        repeat (n) q.push_back(FLAG_CHARS[$urandom_range(8)]);
        // trailing random byte, mostly an unknown flag
        if (kind >= 88)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // request and result monitor: predicts on every accepted request, checks every
    // accepted result, drives the result stall and runs the watchdog
    always @(posedge clk) begin : monitor
        scp_pkg::scp_result_t got;
        if (rst_n) begin
            if (cmd.valid && cmd.ready)
                sb.note_request(cmd.ch, cmd.last, cmd.empty_req);
            if (res.valid && res.ready) begin
                got = '{role:            res.role,
                        done_res:        res.done_res,
                        status:          res.status,
                        flag_set:        res.flag_set,
                        pattern_len:     res.pattern_len,
                        replacement_len: res.replacement_len};
                sb.check_result(got);
            end
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, sb.expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int phase_end;
        sb = new();
        // every input known from time zero
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.ch        = '0;
        cmd.last      = 1'b0;
        cmd.empty_req = 1'b0;
        res.ready     = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 46;
        quiet_cycles  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty request with last set
        send_request(8'hFF, 1'b1, 1'b1);
        // body in progress discarded by an empty request that has last clear
        send_request(",", 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // letter as delimiter, later bytes ignored
        send_text("a/x");
        // escaped delimiter in the pattern, every flag but I, space and tab
        send_text("/\\//x/gcnp \tie");
        // empty fields, i together with I
        send_text("%%%iI");
        // body ends inside the pattern on a backslash that escapes nothing
        send_text("~\\");
        wait_drained();

        // three idling phases: sender light and receiver heavy, swapped, none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 22 : 0;
            phase_end = sb.requests + PHASE_REQUESTS;
            while (sb.requests < phase_end) begin
                if ($urandom_range(99) < 8)
                    send_request(8'($urandom), 1'($urandom), 1'b1);
                else
                    send_body(make_body(), $urandom_range(19) == 0);
                // occasional full drain with the sender held off
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        // short pipeline; leave room for any stray result
        repeat (10) @(posedge clk);

        $display("covered %0d requests: %0d ok, %0d empty, %0d bad delimiter,",
                 sb.requests, sb.bodies[scp_pkg::ST_OK], sb.bodies[scp_pkg::ST_EMPTY],
                 sb.bodies[scp_pkg::ST_BAD_DELIM]);
        $display("%0d unknown flag, %0d i/I conflict, %0d saturated, %0d mismatches",
                 sb.bodies[scp_pkg::ST_BAD_FLAG], sb.bodies[scp_pkg::ST_CONFLICT],
                 sb.saturated, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/scp_pkg.sv
src/scp_cmd_if.sv
src/scp_res_if.sv
src/scp_step.sv
src/substitute_command_splitter.sv
test/testbench.sv
